// File: hdl/mosfet_newton_voltage_limiter_unit_defines.svh
// Assertion macros shared by the voltage limiter RTL.
`ifndef MOSFET_NEWTON_VOLTAGE_LIMITER_UNIT_DEFINES_SVH
`define MOSFET_NEWTON_VOLTAGE_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MNVL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mnvl: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define MNVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mnvl: next-cycle check failed");

`endif

// File: hdl/mnvl_pkg.sv
// Shared types, constants and the constant log helper of the voltage limiter.
package mnvl_pkg;

    localparam int THR_W     = 24;
    localparam int LOG_ITERS = 26;
    localparam int LOG_MW    = 31;
    localparam int LOG_Q     = 30;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Junction step selection
    typedef enum logic [1:0] {
        JL_NONE,
        JL_UP,
        JL_DOWN,
        JL_ABS
    } t_jmode;

    typedef struct packed {
        logic   sel;    // 1: limit on vbs, 0: limit on vbd
        t_jmode mode;
    } t_jctl;

    typedef enum logic {
        REG_POLARITY  = 1'b0,
        REG_THRESHOLD = 1'b1
    } t_reg_idx;

    // Natural log of a positive integer, Q frac; evaluated at elaboration
    function automatic longint ln_const(input longint unsigned n, input int frac);
        int unsigned p;
        longint unsigned m;
        longint unsigned fr;
        longint unsigned l2;
        longint unsigned prd;
        p  = 0;
        fr = 0;
        if (n == 0) begin
            return 0;
        end
        while ((n >> p) > 1) begin
            p++;
        end
        m = (p <= 30) ? (n << (30 - p)) : (n >> (p - 30));
        for (int i = 0; i < LOG_ITERS; i++) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m  = m >> 1;
                fr = fr | (64'd1 << (25 - i));
            end
        end
        l2  = (longint'(p) << 26) + fr;
        prd = l2 * 64'd744261118;
        return longint'((prd + (64'd1 << (55 - frac))) >> (56 - frac));
    endfunction

endpackage

// File: hdl/mnvl_front.sv
// Front pipeline: gate step, drain-source step and junction step setup.
module mnvl_front
    import mnvl_pkg::*;
#(
    parameter int VOLT_WIDTH = 24,
    parameter int FRAC_BITS  = 16,
    parameter int IW         = 32,
    parameter int NW         = 26
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic signed [VOLT_WIDTH-1:0] i_new_gate_bulk,
    input  logic signed [VOLT_WIDTH-1:0] i_new_drain_bulk,
    input  logic signed [VOLT_WIDTH-1:0] i_new_source_bulk,
    input  logic signed [VOLT_WIDTH-1:0] i_old_drain_bulk,
    input  logic signed [VOLT_WIDTH-1:0] i_old_gate_bulk,
    input  logic signed [VOLT_WIDTH-1:0] i_old_source_bulk,
    input  logic                         i_polarity,
    input  logic signed [THR_W-1:0]      i_threshold,
    output logic                         o_vld,
    output t_jctl                        o_ctl,
    output logic [NW-1:0]                o_n,
    output logic signed [IW-1:0]         o_jo,
    output logic signed [IW-1:0]         o_direct,
    output logic signed [IW-1:0]         o_vds,
    output logic signed [IW-1:0]         o_vgs
);

    localparam longint VT_L    = ((64'sd26 <<< FRAC_BITS) + 500) / 1000;
    localparam longint VCRIT_L = ((64'sd6145 <<< FRAC_BITS) + 5000) / 10000;
    localparam logic signed [IW-1:0] C_ZERO  = '0;
    localparam logic signed [IW-1:0] C_ONE   = IW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [IW-1:0] C_HALF  = C_ONE >>> 1;
    localparam logic signed [IW-1:0] C_2     = C_ONE <<< 1;
    localparam logic signed [IW-1:0] C_4     = C_ONE <<< 2;
    localparam logic signed [IW-1:0] C_3H    = C_4 - C_HALF;
    localparam logic signed [IW-1:0] C_VT2   = IW'(VT_L * 2);
    localparam logic signed [IW-1:0] C_VCRIT = IW'(VCRIT_L);

    // Gate step limit around the threshold
    function automatic logic signed [IW-1:0] gate_lim(
        input logic signed [IW-1:0] vn,
        input logic signed [IW-1:0] vo,
        input logic signed [IW-1:0] vto
    );
        logic signed [IW-1:0] d;
        logic signed [IW-1:0] ad;
        logic signed [IW-1:0] hi;
        logic signed [IW-1:0] lo;
        logic signed [IW-1:0] vtox;
        logic signed [IW-1:0] delv;
        logic signed [IW-1:0] vtemp;
        logic signed [IW-1:0] r;
        d     = vo - vto;
        ad    = (d < C_ZERO) ? -d : d;
        hi    = (ad <<< 1) + C_2;
        lo    = ad + C_ONE;
        vtox  = vto + C_3H;
        delv  = vn - vo;
        vtemp = vto + C_HALF;
        r     = vn;
        if (vo >= vto) begin
            if (vo >= vtox) begin
                if (delv <= C_ZERO) begin
                    if (vn >= vtox) begin
                        if (-delv > lo) r = vo - lo;
                    end else if (vn < vto + C_2) begin
                        r = vto + C_2;
                    end
                end else if (delv >= hi) begin
                    r = vo + hi;
                end
            end else if (delv <= C_ZERO) begin
                if (vn < vto - C_HALF) r = vto - C_HALF;
            end else if (vn > vto + C_4) begin
                r = vto + C_4;
            end
        end else if (delv <= C_ZERO) begin
            if (-delv > hi) r = vo - hi;
        end else if (vn <= vtemp) begin
            if (delv > lo) r = vo + lo;
        end else begin
            r = vtemp;
        end
        return r;
    endfunction

    // Drain-source step limit
    function automatic logic signed [IW-1:0] ds_lim(
        input logic signed [IW-1:0] vn,
        input logic signed [IW-1:0] vo
    );
        logic signed [IW-1:0] cap;
        logic signed [IW-1:0] r;
        cap = (vo <<< 1) + vo + C_2;
        r   = vn;
        if (vo >= C_3H) begin
            if (vn > vo) begin
                if (vn > cap) r = cap;
            end else if (vn < C_3H && vn < C_2) begin
                r = C_2;
            end
        end else if (vn > vo) begin
            if (vn > C_4) r = C_4;
        end else if (vn < -C_HALF) begin
            r = -C_HALF;
        end
        return r;
    endfunction

    // Stage 1: node differences and gate branch selection
    logic                 r1_vld, r1_dir;
    logic signed [IW-1:0] r1_gnew, r1_gold, r1_vto, r1_vdsold, r1_vgs, r1_vgd;
    logic signed [IW-1:0] r1_vsb, r1_vdb, r1_vsbold, r1_vdbold;
    logic signed [IW-1:0] w_vgb, w_vdb, w_vsb, w_vdbo, w_vgbo, w_vsbo, w_thr;
    logic signed [IW-1:0] w_vgs, w_vgd, w_vgso, w_vgdo, w_vdso;

    assign w_vgb  = IW'(i_new_gate_bulk);
    assign w_vdb  = IW'(i_new_drain_bulk);
    assign w_vsb  = IW'(i_new_source_bulk);
    assign w_vdbo = IW'(i_old_drain_bulk);
    assign w_vgbo = IW'(i_old_gate_bulk);
    assign w_vsbo = IW'(i_old_source_bulk);
    assign w_thr  = IW'(i_threshold);
    assign w_vgs  = w_vgb - w_vsb;
    assign w_vgd  = w_vgb - w_vdb;
    assign w_vgso = w_vgbo - w_vsbo;
    assign w_vgdo = w_vgbo - w_vdbo;
    assign w_vdso = w_vdbo - w_vsbo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dir    <= (w_vdso >= C_ZERO);
            r1_gnew   <= (w_vdso >= C_ZERO) ? w_vgs : w_vgd;
            r1_gold   <= (w_vdso >= C_ZERO) ? w_vgso : w_vgdo;
            r1_vto    <= i_polarity ? -w_thr : w_thr;
            r1_vdsold <= w_vdso;
            r1_vgs    <= w_vgs;
            r1_vgd    <= w_vgd;
            r1_vsb    <= w_vsb;
            r1_vdb    <= w_vdb;
            r1_vsbold <= w_vsbo;
            r1_vdbold <= w_vdbo;
        end
    end

    // Stage 2: gate step
    logic                 r2_vld, r2_dir;
    logic signed [IW-1:0] r2_glim, r2_vdsold, r2_vgs, r2_vgd;
    logic signed [IW-1:0] r2_vsb, r2_vdb, r2_vsbold, r2_vdbold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dir    <= r1_dir;
            r2_glim   <= gate_lim(r1_gnew, r1_gold, r1_vto);
            r2_vdsold <= r1_vdsold;
            r2_vgs    <= r1_vgs;
            r2_vgd    <= r1_vgd;
            r2_vsb    <= r1_vsb;
            r2_vdb    <= r1_vdb;
            r2_vsbold <= r1_vsbold;
            r2_vdbold <= r1_vdbold;
        end
    end

    // Stage 3: drain-source step, mirrored for reverse mode
    logic                 r3_vld;
    logic signed [IW-1:0] r3_vds, r3_vgs, r3_vsb, r3_vdb, r3_vsbold, r3_vdbold;
    logic signed [IW-1:0] w_dsn, w_dso, w_dsl, w_vds;

    assign w_dsn = r2_dir ? (r2_glim - r2_vgd) : (r2_glim - r2_vgs);
    assign w_dso = r2_dir ? r2_vdsold : -r2_vdsold;
    assign w_dsl = ds_lim(w_dsn, w_dso);
    assign w_vds = r2_dir ? w_dsl : -w_dsl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_vds    <= w_vds;
            r3_vgs    <= r2_dir ? r2_glim : (r2_glim + w_vds);
            r3_vsb    <= r2_vsb;
            r3_vdb    <= r2_vdb;
            r3_vsbold <= r2_vsbold;
            r3_vdbold <= r2_vdbold;
        end
    end

    // Stage 4: junction selection and log argument
    logic                 w_sel, w_cond;
    logic signed [IW-1:0] w_jn, w_jo, w_diff, w_adiff, w_arg, w_n, w_direct;
    t_jmode               w_mode;

    assign w_sel   = (r3_vds >= C_ZERO);
    assign w_jn    = w_sel ? -r3_vsb : -r3_vdb;
    assign w_jo    = w_sel ? -r3_vsbold : -r3_vdbold;
    assign w_diff  = w_jn - w_jo;
    assign w_adiff = (w_diff < C_ZERO) ? -w_diff : w_diff;
    assign w_cond  = (w_jn > C_VCRIT) && (w_adiff > C_VT2);
    assign w_arg   = (w_jo > C_ZERO) ? (-w_jo - C_ONE) : ((w_jo <<< 1) - C_ONE);
    assign w_direct = (w_jn < C_ZERO && w_jn < w_arg) ? w_arg : w_jn;

    always_comb begin
        w_mode = JL_NONE;
        w_n    = w_jn;
        if (w_cond) begin
            if (w_jo > C_ZERO) begin
                if (w_diff > C_ZERO) begin
                    w_mode = JL_UP;
                    w_n    = w_diff - C_VT2;
                end else begin
                    w_mode = JL_DOWN;
                    w_n    = C_VT2 - w_diff;
                end
            end else begin
                w_mode = JL_ABS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.sel  <= w_sel;
            o_ctl.mode <= w_mode;
            o_n        <= w_n[NW-1:0];
            o_jo       <= w_jo;
            o_direct   <= w_direct;
            o_vds      <= r3_vds;
            o_vgs      <= r3_vgs;
        end
    end

endmodule

// File: hdl/mnvl_log_pipe.sv
// Pipelined natural log by repeated squaring, one squaring per stage.
module mnvl_log_pipe
    import mnvl_pkg::*;
#(
    parameter int NW        = 26,
    parameter int FRAC_BITS = 16,
    parameter int SBW       = 8,
    parameter int LW        = FRAC_BITS + 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [NW-1:0]  i_n,
    input  logic [SBW-1:0] i_sb,
    output logic           o_vld,
    output logic [LW-1:0]  o_l,
    output logic [SBW-1:0] o_sb
);

    localparam int PW    = $clog2(NW);
    localparam int NMW   = NW + LOG_MW;
    localparam int SHIFT = 56 - FRAC_BITS;
    localparam int PRW   = PW + 56;
    localparam logic [PRW-1:0] RND = PRW'(1) << (SHIFT - 1);

    // Stage 0: position of the leading one
    logic           r0_vld;
    logic [NW-1:0]  r0_n;
    logic [PW-1:0]  r0_p;
    logic [SBW-1:0] r0_sb;
    logic [PW-1:0]  w_p;

    always_comb begin
        w_p = '0;
        for (int k = 0; k < NW; k++) begin
            if (i_n[k]) w_p = PW'(k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_n  <= i_n;
            r0_p  <= w_p;
            r0_sb <= i_sb;
        end
    end

    // Stage 1: normalize mantissa to Q30 in [1, 2)
    logic [LOG_MW-1:0]    r_m [LOG_ITERS+1];
    logic [LOG_ITERS-1:0] r_f [LOG_ITERS+1];
    logic [PW-1:0]        r_p [LOG_ITERS+1];
    logic [SBW-1:0]       r_s [LOG_ITERS+1];
    logic                 r_v [LOG_ITERS+1];
    logic [PW-1:0]        w_sh;
    logic [NMW-1:0]       w_norm;

    assign w_sh   = PW'(NW - 1) - r0_p;
    assign w_norm = {r0_n, {LOG_MW{1'b0}}} << w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= w_norm[NMW-1 -: LOG_MW];
            r_f[0] <= '0;
            r_p[0] <= r0_p;
            r_s[0] <= r0_sb;
        end
    end

    // Square, renormalize and shift in one fraction bit per stage
    for (genvar g = 0; g < LOG_ITERS; g++) begin : g_sq
        logic [2*LOG_MW-1:0] w_sq;
        logic [LOG_MW:0]     w_t;

        assign w_sq = r_m[g] * r_m[g];
        assign w_t  = w_sq[2*LOG_MW-1:LOG_Q];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g+1] <= w_t[LOG_MW] ? w_t[LOG_MW:1] : w_t[LOG_MW-1:0];
                r_f[g+1] <= {r_f[g][LOG_ITERS-2:0], w_t[LOG_MW]};
                r_p[g+1] <= r_p[g];
                r_s[g+1] <= r_s[g];
            end
        end
    end

    // Scale log2 by ln 2
    logic           r_pr_vld;
    logic [PRW-1:0] r_prod;
    logic [SBW-1:0] r_pr_sb;
    logic [PW+LOG_ITERS-1:0] w_l2;
    logic [PRW-1:0] w_sum;

    assign w_l2  = {r_p[LOG_ITERS], r_f[LOG_ITERS]};
    assign w_sum = r_prod + RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_vld <= 1'b0;
            o_vld    <= 1'b0;
        end else if (i_en) begin
            r_pr_vld <= r_v[LOG_ITERS];
            o_vld    <= r_pr_vld;
        end
    end

    // Round to the output fraction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PRW'(w_l2) * PRW'(LN2_Q30);
            r_pr_sb <= r_s[LOG_ITERS];
            o_l     <= w_sum[SHIFT +: LW];
            o_sb    <= r_pr_sb;
        end
    end

endmodule

// File: hdl/mosfet_newton_voltage_limiter_unit.sv
// Top level of the MOS Newton voltage limiter: config, pipeline, output stages.
//
//  channel   | direction | handshake                      | contents
//  s_axis    | in        | tvalid/tready                  | six old/new node voltages
//  m_axis    | out       | tvalid/tready                  | limited drain, gate, source
//  apb       | in/out    | psel, penable, pwrite, pready  | polarity, threshold
//
// One word is accepted per cycle while the output is not held; there are 4 front
// stages, 30 log stages (26 of them one squaring multiply each) and 3 back stages.
// Reset is synchronous, active low; it clears valid bits and config registers.
// A held output word stalls every stage at once; nothing is dropped or repeated.
`include "mosfet_newton_voltage_limiter_unit_defines.svh"

module mosfet_newton_voltage_limiter_unit
    import mnvl_pkg::*;
#(
    parameter int VOLT_WIDTH = 24,
    parameter int FRAC_BITS  = 16,
    localparam int IDW = ((6 * VOLT_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((3 * VOLT_WIDTH + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // new_gate_bulk, new_drain_bulk, new_source_bulk,
    // old_drain_bulk, old_gate_bulk, old_source_bulk
    input  logic [IDW-1:0] s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // lim_drain_bulk, lim_gate_bulk, lim_source_bulk
    output logic [ODW-1:0] m_axis_tdata
);

    localparam int W   = VOLT_WIDTH;
    localparam int M   = (VOLT_WIDTH > THR_W) ? VOLT_WIDTH : THR_W;
    localparam int IW  = M + 8;
    localparam int NW  = M + 2;
    localparam int LW  = FRAC_BITS + 5;
    localparam int XW  = FRAC_BITS + 9;
    localparam int VTW = FRAC_BITS - 4;
    localparam int PRW = XW + VTW + 1;
    localparam int SBW = $bits(t_jctl) + 4 * IW;
    localparam longint VT_L  = ((64'sd26 <<< FRAC_BITS) + 500) / 1000;
    localparam longint LVT_L = ln_const(longint'(VT_L), FRAC_BITS);
    localparam logic signed [VTW:0]    C_VT   = (VTW + 1)'(VT_L);
    localparam logic signed [XW-1:0]   C_LVT  = XW'(LVT_L);
    localparam logic signed [XW-1:0]   C_TWO  = XW'(64'sd2 <<< FRAC_BITS);
    localparam logic signed [XW-1:0]   C_XZ   = '0;
    localparam logic signed [PRW-1:0]  C_PZ   = '0;
    localparam logic [PRW-1:0]         C_RND  = PRW'(1) << (FRAC_BITS - 1);
    localparam logic signed [IW-1:0]   V_MAX  = IW'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [IW-1:0]   V_MIN  = -V_MAX - IW'(1);

    // Saturate to the output voltage range
    function automatic logic [W-1:0] sat_v(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] r;
        r = v;
        if (r > V_MAX) r = V_MAX;
        if (r < V_MIN) r = V_MIN;
        return r[W-1:0];
    endfunction

    // Configuration registers
    logic             r_pol;
    logic [THR_W-1:0] r_thr;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol <= 1'b0;
            r_thr <= THR_W'(31850);
        end else if (w_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_POLARITY:  r_pol <= pwdata[0];
                REG_THRESHOLD: r_thr <= pwdata[THR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_POLARITY:  prdata = {31'b0, r_pol};
            REG_THRESHOLD: prdata = {{(32 - THR_W){1'b0}}, r_thr};
        endcase
    end

    // Pipeline advance: output register empty or being taken
    logic r_m_vld;
    logic w_adv;

    assign w_adv         = !r_m_vld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_m_vld;

    // Front stages
    logic                 w_fr_vld;
    t_jctl                w_fr_ctl;
    logic [NW-1:0]        w_fr_n;
    logic signed [IW-1:0] w_fr_jo, w_fr_dir, w_fr_vds, w_fr_vgs;

    mnvl_front #(
        .VOLT_WIDTH (VOLT_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .IW         (IW),
        .NW         (NW)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_adv),
        .i_vld             (s_axis_tvalid),
        .i_new_gate_bulk   (s_axis_tdata[0*W +: W]),
        .i_new_drain_bulk  (s_axis_tdata[1*W +: W]),
        .i_new_source_bulk (s_axis_tdata[2*W +: W]),
        .i_old_drain_bulk  (s_axis_tdata[3*W +: W]),
        .i_old_gate_bulk   (s_axis_tdata[4*W +: W]),
        .i_old_source_bulk (s_axis_tdata[5*W +: W]),
        .i_polarity        (r_pol),
        .i_threshold       (r_thr),
        .o_vld             (w_fr_vld),
        .o_ctl             (w_fr_ctl),
        .o_n               (w_fr_n),
        .o_jo              (w_fr_jo),
        .o_direct          (w_fr_dir),
        .o_vds             (w_fr_vds),
        .o_vgs             (w_fr_vgs)
    );

    // Log unit, side data rides along
    logic           w_lg_vld;
    logic [LW-1:0]  w_lg_l;
    logic [SBW-1:0] w_lg_sb;

    mnvl_log_pipe #(
        .NW        (NW),
        .FRAC_BITS (FRAC_BITS),
        .SBW       (SBW),
        .LW        (LW)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_fr_vld),
        .i_n     (w_fr_n),
        .i_sb    ({w_fr_ctl, w_fr_jo, w_fr_dir, w_fr_vds, w_fr_vgs}),
        .o_vld   (w_lg_vld),
        .o_l     (w_lg_l),
        .o_sb    (w_lg_sb)
    );

    t_jctl                w_lg_ctl;
    logic signed [IW-1:0] w_lg_jo, w_lg_dir, w_lg_vds, w_lg_vgs;
    logic signed [XW-1:0] w_x;

    assign {w_lg_ctl, w_lg_jo, w_lg_dir, w_lg_vds, w_lg_vgs} = w_lg_sb;
    assign w_x = (XW'({1'b0, w_lg_l}) - C_LVT)
               + ((w_lg_ctl.mode == JL_ABS) ? C_XZ : C_TWO);

    // Back stage 1: multiply by thermal voltage
    logic                  r_b1_vld;
    t_jctl                 r_b1_ctl;
    logic signed [PRW-1:0] r_b1_prod;
    logic signed [IW-1:0]  r_b1_jo, r_b1_dir, r_b1_vds, r_b1_vgs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else if (w_adv) begin
            r_b1_vld <= w_lg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_ctl  <= w_lg_ctl;
            r_b1_prod <= PRW'(C_VT) * PRW'(w_x);
            r_b1_jo   <= w_lg_jo;
            r_b1_dir  <= w_lg_dir;
            r_b1_vds  <= w_lg_vds;
            r_b1_vgs  <= w_lg_vgs;
        end
    end

    // Back stage 2: round, apply junction step, rebuild vbs and vbd
    logic [PRW-1:0]        w_mag, w_rnd;
    logic signed [PRW-1:0] w_rs;
    logic signed [IW-1:0]  w_r, w_jl;
    logic                  r_b2_vld;
    logic signed [IW-1:0]  r_b2_vbs, r_b2_vbd, r_b2_vgs;

    assign w_mag = (r_b1_prod < C_PZ) ? PRW'(-r_b1_prod) : PRW'(r_b1_prod);
    assign w_rnd = (w_mag + C_RND) >> FRAC_BITS;
    assign w_rs  = (r_b1_prod < C_PZ) ? -signed'(w_rnd) : signed'(w_rnd);
    assign w_r   = IW'(w_rs);

    always_comb begin
        w_jl = r_b1_dir;
        case (r_b1_ctl.mode)
            JL_UP:   w_jl = r_b1_jo + w_r;
            JL_DOWN: w_jl = r_b1_jo - w_r;
            JL_ABS:  w_jl = w_r;
            JL_NONE: w_jl = r_b1_dir;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_vld <= 1'b0;
        end else if (w_adv) begin
            r_b2_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b2_vbs <= r_b1_ctl.sel ? w_jl : (w_jl + r_b1_vds);
            r_b2_vbd <= r_b1_ctl.sel ? (w_jl - r_b1_vds) : w_jl;
            r_b2_vgs <= r_b1_vgs;
        end
    end

    // Back stage 3: saturate into the output word
    logic [W-1:0] r_m_drain, r_m_gate, r_m_source;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_adv) begin
            r_m_vld <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_drain  <= sat_v(-r_b2_vbd);
            r_m_gate   <= sat_v(r_b2_vgs - r_b2_vbs);
            r_m_source <= sat_v(-r_b2_vbs);
        end
    end

    assign m_axis_tdata = {{(ODW - 3 * W){1'b0}}, r_m_source, r_m_gate, r_m_drain};

    // Checks
    `MNVL_ASSERT_NXT(a_thr_write, i_clk, i_rst_n,
        w_wr && paddr[2] == REG_THRESHOLD, r_thr == $past(pwdata[THR_W-1:0]))
    `MNVL_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n,
        !w_adv, $stable({w_lg_vld, r_b1_vld, r_b2_vld, r_m_vld}))
    `MNVL_ASSERT_IMP(a_abs_log_pos, i_clk, i_rst_n,
        w_lg_vld && w_lg_ctl.mode == JL_ABS, w_x >= C_XZ)

endmodule
